[hdl/format_spec_parser_defines.svh]
// Assertion macros used by the format_spec_parser module
`ifndef FORMAT_SPEC_PARSER_DEFINES_SVH
`define FORMAT_SPEC_PARSER_DEFINES_SVH

// same-cycle implication
`define FSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format_spec_parser: check failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format_spec_parser: check failed");

`endif

[hdl/fsp_pkg.sv]
package fsp_pkg;

    typedef enum logic [2:0] {
        PH_FLAGS = 3'd0,
        PH_WIDTH = 3'd1,
        PH_PREC  = 3'd2,
        PH_H     = 3'd3,
        PH_L     = 3'd4,
        PH_MODOK = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        MOD_NONE = 3'd0,
        MOD_H    = 3'd1,
        MOD_HH   = 3'd2,
        MOD_L    = 3'd3,
        MOD_LL   = 3'd4,
        MOD_J    = 3'd5,
        MOD_Z    = 3'd6
    } mod_t;

    localparam int FB_ALT   = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_LEFT  = 2;
    localparam int FB_PLUS  = 3;
    localparam int FB_SPACE = 4;

    localparam logic [15:0] SAT_MAX = 16'hFFFF;

    localparam logic [4:0] BASE_NONE = 5'd0;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    localparam logic [7:0] CASE_SHIFT = 8'd32;

    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_H     = "h";
    localparam logic [7:0] CH_L     = "l";
    localparam logic [7:0] CH_J     = "j";
    localparam logic [7:0] CH_Z     = "z";
    localparam logic [7:0] CH_D_LO  = "d";
    localparam logic [7:0] CH_I_LO  = "i";
    localparam logic [7:0] CH_U_LO  = "u";
    localparam logic [7:0] CH_O_LO  = "o";
    localparam logic [7:0] CH_X_LO  = "x";
    localparam logic [7:0] CH_P_LO  = "p";
    localparam logic [7:0] CH_C_LO  = "c";
    localparam logic [7:0] CH_S_LO  = "s";
    localparam logic [7:0] CH_D_UP  = "D";
    localparam logic [7:0] CH_U_UP  = "U";
    localparam logic [7:0] CH_O_UP  = "O";
    localparam logic [7:0] CH_X_UP  = "X";
    localparam logic [7:0] CH_C_UP  = "C";
    localparam logic [7:0] CH_S_UP  = "S";

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  flags;
        logic [15:0] width;
        logic [15:0] prec;
        logic        prec_seen;
        mod_t        modifier;
    } st_t;

    localparam st_t ST_RESET = '{
        phase:     PH_FLAGS,
        flags:     5'd0,
        width:     16'd0,
        prec:      16'd0,
        prec_seen: 1'b0,
        modifier:  MOD_NONE
    };

    typedef struct packed {
        logic        flag_alt;
        logic        flag_zero;
        logic        flag_left;
        logic        flag_plus;
        logic        flag_space;
        logic [15:0] field_width;
        logic [15:0] prec_value;
        logic        prec_given;
        logic [2:0]  length_mod;
        logic [7:0]  conversion;
        logic [4:0]  number_base;
    } rec_t;

    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] ch);
        logic [20:0] sum;
        sum = {2'b00, acc, 3'b000} + {4'b0000, acc, 1'b0} + {17'd0, ch[3:0]};
        add_digit = (sum > {5'd0, SAT_MAX}) ? SAT_MAX : sum[15:0];
    endfunction

    function automatic logic [4:0] flag_of(input logic [7:0] ch);
        logic [4:0] f;
        f = 5'd0;
        if (ch == CH_HASH)  f[FB_ALT]   = 1'b1;
        if (ch == CH_ZERO)  f[FB_ZERO]  = 1'b1;
        if (ch == CH_MINUS) f[FB_LEFT]  = 1'b1;
        if (ch == CH_PLUS)  f[FB_PLUS]  = 1'b1;
        if (ch == CH_SPACE) f[FB_SPACE] = 1'b1;
        flag_of = f;
    endfunction

endpackage

[hdl/fsp_parse.sv]
module fsp_parse
(
    input  fsp_pkg::st_t  st,
    input  logic [7:0]    char_code,
    input  logic          spec_start,
    output fsp_pkg::st_t  st_next,
    output logic          emit,
    output fsp_pkg::rec_t rec
);
    import fsp_pkg::*;

    st_t        s;
    logic [4:0] fl_in;
    logic       is_digit;
    logic       is_dot;
    logic       go_width;
    logic [4:0] fl;
    logic [4:0] base;
    logic [7:0] conv;
    mod_t       mod;

    assign s        = spec_start ? ST_RESET : st;
    assign fl_in    = flag_of(char_code);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_dot   = (char_code == CH_DOT);
    assign go_width = ((s.phase == PH_FLAGS) && (fl_in == 5'd0)) || (s.phase == PH_WIDTH);

    always_comb
    begin
        st_next = s;
        emit    = 1'b0;
        case (s.phase)
            PH_FLAGS, PH_WIDTH, PH_PREC:
            begin
                if ((s.phase == PH_FLAGS) && (fl_in != 5'd0))
                begin
                    st_next.flags = s.flags | fl_in;
                end
                else if (is_digit)
                begin
                    if (go_width)
                    begin
                        st_next.width = add_digit(s.width, char_code);
                        st_next.phase = PH_WIDTH;
                    end
                    else
                    begin
                        st_next.prec = add_digit(s.prec, char_code);
                    end
                end
                else if (is_dot && go_width)
                begin
                    st_next.prec_seen = 1'b1;
                    st_next.prec      = 16'd0;
                    st_next.phase     = PH_PREC;
                end
                else if (char_code == CH_H)
                begin
                    st_next.modifier = MOD_H;
                    st_next.phase    = PH_H;
                end
                else if (char_code == CH_L)
                begin
                    st_next.modifier = MOD_L;
                    st_next.phase    = PH_L;
                end
                else if (char_code == CH_J)
                begin
                    st_next.modifier = MOD_J;
                    st_next.phase    = PH_MODOK;
                end
                else if (char_code == CH_Z)
                begin
                    st_next.modifier = MOD_Z;
                    st_next.phase    = PH_MODOK;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_H:
            begin
                if (char_code == CH_H)
                begin
                    st_next.modifier = MOD_HH;
                    st_next.phase    = PH_MODOK;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_L:
            begin
                if (char_code == CH_L)
                begin
                    st_next.modifier = MOD_LL;
                    st_next.phase    = PH_MODOK;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b1;
            end
        endcase
        if (emit)
        begin
            st_next = ST_RESET;
        end
    end

    always_comb
    begin
        conv = char_code;
        mod  = s.modifier;
        fl   = s.flags;
        if ((conv == CH_D_LO) || (conv == CH_I_LO) || (conv == CH_U_LO) ||
            (conv == CH_D_UP) || (conv == CH_U_UP))
        begin
            base = BASE_DEC;
        end
        else if ((conv == CH_O_LO) || (conv == CH_O_UP))
        begin
            base = BASE_OCT;
        end
        else if ((conv == CH_X_LO) || (conv == CH_X_UP) || (conv == CH_P_LO))
        begin
            base = BASE_HEX;
        end
        else
        begin
            base = BASE_NONE;
        end
        if ((conv == CH_D_UP) || (conv == CH_O_UP) || (conv == CH_U_UP))
        begin
            conv = conv + CASE_SHIFT;
            mod  = MOD_L;
        end
        if (fl[FB_LEFT])
        begin
            fl[FB_ZERO] = 1'b0;
        end
        if (fl[FB_PLUS])
        begin
            fl[FB_SPACE] = 1'b0;
        end
        if (s.prec_seen && (base != BASE_NONE))
        begin
            fl[FB_ZERO] = 1'b0;
        end
        if ((conv == CH_C_LO) && (mod == MOD_L))
        begin
            conv = CH_C_UP;
        end
        else if ((conv == CH_S_LO) && (mod == MOD_L))
        begin
            conv = CH_S_UP;
        end

        rec.flag_alt    = fl[FB_ALT];
        rec.flag_zero   = fl[FB_ZERO];
        rec.flag_left   = fl[FB_LEFT];
        rec.flag_plus   = fl[FB_PLUS];
        rec.flag_space  = fl[FB_SPACE];
        rec.field_width = s.width;
        rec.prec_value  = s.prec;
        rec.prec_given  = s.prec_seen;
        rec.length_mod  = mod;
        rec.conversion  = conv;
        rec.number_base = base;
    end

endmodule

[hdl/format_spec_parser.sv]
// format_spec_parser: streaming parser for one printf conversion specification.
// Input channel (char_valid / char_stall): one byte of the specification per
// transfer, starting after the percent sign; spec_start marks the first byte and
// clears any partial parse. Flags, width, dot and precision, and length modifier
// bytes only update internal state; the conversion byte ends the specification.
// Output channel (rec_valid / rec_stall): one record per conversion byte with
// the flags, width, precision, modifier, conversion and number base.
// After a conversion byte transfer, the byte goes into the input register and
// the record is then loaded into the record register, where it can be taken.
// Throughput: one byte per cycle while char_stall is low; the parse state updates
// from the input register into the state and record registers.
// When rec_stall is high and a record is held, the byte in the input register
// waits and char_stall rises until the held record is taken; a record taken in
// the same cycle frees the input register for the next byte.
// Reset (rst_n low, asynchronous) empties both registers and returns the parse
// state to the flags phase with all fields cleared.
`include "format_spec_parser_defines.svh"

module format_spec_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        spec_start,
    output logic        rec_valid,
    input  logic        rec_stall,
    output logic        flag_alt,
    output logic        flag_zero,
    output logic        flag_left,
    output logic        flag_plus,
    output logic        flag_space,
    output logic [15:0] field_width,
    output logic [15:0] prec_value,
    output logic        prec_given,
    output logic [2:0]  length_mod,
    output logic [7:0]  conversion,
    output logic [4:0]  number_base
);
    import fsp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_reg;
    logic       start_reg;
    st_t        st_reg;
    st_t        st_next;
    logic       rec_valid_reg;
    logic       rec_valid_next;
    rec_t       rec_reg;
    rec_t       rec_new;
    logic       emit;
    logic       advance;
    logic       take_in;

    fsp_parse u_parse
    (
        .st         (st_reg),
        .char_code  (char_reg),
        .spec_start (start_reg),
        .st_next    (st_next),
        .emit       (emit),
        .rec        (rec_new)
    );

    assign advance    = in_valid_reg && (!rec_valid_reg || !rec_stall);
    assign char_stall = in_valid_reg && !advance;
    assign take_in    = char_valid && !char_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (advance && emit)
        begin
            rec_valid_next = 1'b1;
        end
        else if (!rec_stall)
        begin
            rec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
            st_reg        <= ST_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rec_valid_reg <= rec_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            char_reg  <= char_code;
            start_reg <= spec_start;
        end
        if (advance && emit)
        begin
            rec_reg <= rec_new;
        end
    end

    assign rec_valid   = rec_valid_reg;
    assign flag_alt    = rec_reg.flag_alt;
    assign flag_zero   = rec_reg.flag_zero;
    assign flag_left   = rec_reg.flag_left;
    assign flag_plus   = rec_reg.flag_plus;
    assign flag_space  = rec_reg.flag_space;
    assign field_width = rec_reg.field_width;
    assign prec_value  = rec_reg.prec_value;
    assign prec_given  = rec_reg.prec_given;
    assign length_mod  = rec_reg.length_mod;
    assign conversion  = rec_reg.conversion;
    assign number_base = rec_reg.number_base;

    `FSP_ASSERT_NOW(a_stall_only_when_held, char_stall, in_valid_reg && rec_valid_reg)
    `FSP_ASSERT_NEXT(a_emit_loads_record, advance && emit, rec_valid_reg)
    `FSP_ASSERT_NEXT(a_emit_clears_state, advance && emit, st_reg == ST_RESET)
    `FSP_ASSERT_NOW(a_hh_ends_modifier, st_reg.modifier == MOD_HH, st_reg.phase == PH_MODOK)
    `FSP_ASSERT_NOW(a_prec_needs_dot, st_reg.prec != 16'd0, st_reg.prec_seen)

endmodule
